### rtl/sensor_adc_piecewise_linearize_top_macros.svh
`ifndef SENSOR_ADC_PIECEWISE_LINEARIZE_TOP_MACROS_SVH
`define SENSOR_ADC_PIECEWISE_LINEARIZE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define SLPL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define SLPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/slpl_pkg.sv
`timescale 1ns / 1ps

package slpl_pkg;

  localparam int unsigned MAX_POINTS    = 6;
  localparam int unsigned STORED_POINTS = 6;
  localparam int unsigned PT_LIMIT      =
    (MAX_POINTS < STORED_POINTS) ? MAX_POINTS : STORED_POINTS;
  localparam int unsigned PT_W          = 3;

  localparam int unsigned VAL_W      = 16;
  localparam int unsigned ADC_W      = 8;
  localparam int unsigned CNUM_W     = 24;
  localparam int unsigned CDEN_W     = 9;
  localparam int unsigned CDIV_STEPS = CNUM_W;
  localparam int unsigned IDIV_STEPS = VAL_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [ADC_W-1:0]  RES_FAULT_MIN  = 8'd195;
  localparam logic [ADC_W-1:0]  VOLT_FAULT_MAX = 8'd6;
  localparam logic [6:0]        RES_OFFSET     = 7'd127;
  localparam logic [CDEN_W-1:0] RES_BASE       = 9'd242;
  localparam logic [CDEN_W-1:0] VOLT_DIVISOR   = 9'd480;
  localparam logic [VAL_W-1:0]  FAULT_VALUE    = 16'hfffe;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT  = 3'd0,
    REG_SENSOR_KIND  = 3'd1,
    REG_INPUT_RATIO  = 3'd2,
    REG_KNEE_X_FIRST = 3'd3,
    REG_KNEE_X_LAST  = 3'd4,
    REG_KNEE_Y_FIRST = 3'd5,
    REG_KNEE_Y_LAST  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FAULT    = 2'd1,
    ST_DISABLED = 2'd2,
    ST_NOSEG    = 2'd3
  } status_e;

  typedef struct packed {
    logic [PT_W-1:0]                         n;
    logic                                    kind;
    logic [VAL_W-1:0]                        ratio;
    logic [STORED_POINTS-1:0][VAL_W-1:0]     knee_x;
    logic [STORED_POINTS-1:0][VAL_W-1:0]     knee_y;
  } cfg_t;

  typedef struct packed {
    status_e           st;
    logic [CNUM_W-1:0] num;
    logic [CDEN_W-1:0] den;
  } job_t;

  typedef struct packed {
    status_e           st;
    logic [CDEN_W-1:0] den;
    logic [CDEN_W-1:0] rem;
    logic [CNUM_W-1:0] nq;
  } cdiv_t;

  typedef struct packed {
    status_e          st;
    logic             direct;
    logic [VAL_W-1:0] r;
    logic [VAL_W-1:0] x1;
    logic [VAL_W-1:0] x2;
    logic [VAL_W-1:0] y1;
    logic [VAL_W-1:0] y2;
  } seg_t;

  typedef struct packed {
    status_e          st;
    logic             direct;
    logic             rise;
    logic [VAL_W-1:0] y1;
    logic [VAL_W-1:0] d;
    logic [VAL_W-1:0] p;
  } mul_t;

  typedef struct packed {
    status_e          st;
    logic             direct;
    logic             rise;
    logic [VAL_W-1:0] y1;
    logic [VAL_W-1:0] d;
    logic [VAL_W-1:0] rem;
    logic [VAL_W-1:0] nq;
  } idiv_t;

endpackage

### rtl/slpl_front.sv
`timescale 1ns / 1ps

module slpl_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [slpl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [slpl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  input  logic [slpl_pkg::ADC_W-1:0]       adc_sample_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output slpl_pkg::job_t                   job_o,
  output slpl_pkg::cfg_t                   cfg_o
);

  logic [slpl_pkg::PT_W-1:0]       point_count_q;
  logic                            sensor_kind_q;
  logic [slpl_pkg::VAL_W-1:0]      input_ratio_q;
  logic [slpl_pkg::CFG_DATA_W-1:0] knee_x_first_q;
  logic [slpl_pkg::CFG_DATA_W-1:0] knee_x_last_q;
  logic [slpl_pkg::CFG_DATA_W-1:0] knee_y_first_q;
  logic [slpl_pkg::CFG_DATA_W-1:0] knee_y_last_q;

  logic [slpl_pkg::PT_W-1:0]   n_sat;
  logic [slpl_pkg::CNUM_W-1:0] prod;
  logic [6:0]                  res_off;
  logic                        fault;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q  <= '0;
      sensor_kind_q  <= 1'b0;
      input_ratio_q  <= '0;
      knee_x_first_q <= '0;
      knee_x_last_q  <= '0;
      knee_y_first_q <= '0;
      knee_y_last_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (slpl_pkg::cfg_reg_e'(cfg_index_i))
        slpl_pkg::REG_POINT_COUNT:  point_count_q  <= cfg_data_i[slpl_pkg::PT_W-1:0];
        slpl_pkg::REG_SENSOR_KIND:  sensor_kind_q  <= cfg_data_i[0];
        slpl_pkg::REG_INPUT_RATIO:  input_ratio_q  <= cfg_data_i[slpl_pkg::VAL_W-1:0];
        slpl_pkg::REG_KNEE_X_FIRST: knee_x_first_q <= cfg_data_i;
        slpl_pkg::REG_KNEE_X_LAST:  knee_x_last_q  <= cfg_data_i;
        slpl_pkg::REG_KNEE_Y_FIRST: knee_y_first_q <= cfg_data_i;
        slpl_pkg::REG_KNEE_Y_LAST:  knee_y_last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign n_sat = (point_count_q > slpl_pkg::PT_W'(slpl_pkg::PT_LIMIT)) ?
                 slpl_pkg::PT_W'(slpl_pkg::PT_LIMIT) : point_count_q;

  always_comb begin
    cfg_o.n      = n_sat;
    cfg_o.kind   = sensor_kind_q;
    cfg_o.ratio  = input_ratio_q;
    cfg_o.knee_x = {knee_x_last_q, knee_x_first_q};
    cfg_o.knee_y = {knee_y_last_q, knee_y_first_q};
  end

  // classify the word and set up the first division
  always_comb begin
    prod    = {8'd0, input_ratio_q} * {16'd0, adc_sample_i};
    res_off = slpl_pkg::RES_OFFSET - adc_sample_i[7:1];
    fault   = sensor_kind_q ? (adc_sample_i <= slpl_pkg::VOLT_FAULT_MAX)
                            : (adc_sample_i >= slpl_pkg::RES_FAULT_MIN);
    if (n_sat == '0) begin
      job_o.st = slpl_pkg::ST_DISABLED;
    end else if (fault) begin
      job_o.st = slpl_pkg::ST_FAULT;
    end else begin
      job_o.st = slpl_pkg::ST_OK;
    end
    if (sensor_kind_q) begin
      job_o.num = prod;
      job_o.den = slpl_pkg::VOLT_DIVISOR;
    end else begin
      job_o.num = prod + slpl_pkg::CNUM_W'(res_off);
      job_o.den = slpl_pkg::RES_BASE - {1'b0, adc_sample_i};
    end
  end

  assign push_o = in_valid_i && !q_full_i;

endmodule

### rtl/slpl_queue.sv
`timescale 1ns / 1ps

module slpl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slpl_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output slpl_pkg::job_t job_o
);

  slpl_pkg::job_t                     mem_q [slpl_pkg::QUEUE_DEPTH];
  logic [slpl_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
  logic [slpl_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
  logic [slpl_pkg::QUEUE_CNT_W-1:0]   cnt_q;
  logic [slpl_pkg::QUEUE_CNT_W-1:0]   cnt_d;

  localparam logic [slpl_pkg::QUEUE_PTR_W-1:0] LastPtr =
    slpl_pkg::QUEUE_PTR_W'(slpl_pkg::QUEUE_DEPTH - 1);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign full_o  = (cnt_q == slpl_pkg::QUEUE_CNT_W'(slpl_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

endmodule

### rtl/slpl_back.sv
`timescale 1ns / 1ps

module slpl_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slpl_pkg::cfg_t              cfg_i,
  input  logic                        q_valid_i,
  input  slpl_pkg::job_t              q_job_i,
  output logic                        q_pop_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [slpl_pkg::VAL_W-1:0]  physical_value_o,
  output logic [1:0]                  conv_status_o
);

  localparam int unsigned CS = slpl_pkg::CDIV_STEPS;
  localparam int unsigned IS = slpl_pkg::IDIV_STEPS;
  localparam int unsigned VW = slpl_pkg::VAL_W;

  logic adv;

  logic [CS:0]     cdiv_v_q;
  slpl_pkg::cdiv_t cdiv_q [CS+1];
  slpl_pkg::cdiv_t cdiv_d [CS+1];
  logic [slpl_pkg::CDEN_W:0] ctrial;

  logic           seg_v_q;
  slpl_pkg::seg_t seg_q;
  slpl_pkg::seg_t seg_d;

  logic           mul_v_q;
  slpl_pkg::mul_t mul_q;
  slpl_pkg::mul_t mul_d;

  logic [IS:0]     idiv_v_q;
  slpl_pkg::idiv_t idiv_q [IS+1];
  slpl_pkg::idiv_t idiv_d [IS+1];
  logic [VW:0]     itrial;

  logic              out_v_q;
  logic [VW-1:0]     out_val_q;
  slpl_pkg::status_e out_st_q;
  logic [VW-1:0]     out_val_d;

  logic [VW-1:0]   rd;
  logic [VW-1:0]   xl;
  logic [VW-1:0]   yl;
  logic            found;
  logic [VW-1:0]   fx1;
  logic [VW-1:0]   fx2;
  logic [VW-1:0]   fy1;
  logic [VW-1:0]   fy2;
  logic [VW-1:0]   dx;
  logic [VW-1:0]   dy;
  logic [VW-1:0]   diff;
  logic [2*VW-1:0] prod;
  logic            rise;
  logic [VW-1:0]   quo;

  assign adv     = !(out_v_q && out_stall_i);
  assign q_pop_o = adv && q_valid_i;

  // reading = numerator / divisor, one quotient bit per stage
  always_comb begin
    cdiv_d[0].st  = q_job_i.st;
    cdiv_d[0].den = q_job_i.den;
    cdiv_d[0].rem = '0;
    cdiv_d[0].nq  = q_job_i.num;
    ctrial        = '0;
    for (int k = 0; k < CS; k++) begin
      ctrial = {cdiv_q[k].rem, cdiv_q[k].nq[CS-1]};
      cdiv_d[k+1].st  = cdiv_q[k].st;
      cdiv_d[k+1].den = cdiv_q[k].den;
      if (ctrial >= {1'b0, cdiv_q[k].den}) begin
        cdiv_d[k+1].rem = slpl_pkg::CDEN_W'(ctrial - {1'b0, cdiv_q[k].den});
        cdiv_d[k+1].nq  = {cdiv_q[k].nq[CS-2:0], 1'b1};
      end else begin
        cdiv_d[k+1].rem = ctrial[slpl_pkg::CDEN_W-1:0];
        cdiv_d[k+1].nq  = {cdiv_q[k].nq[CS-2:0], 1'b0};
      end
    end
  end

  // clamp and segment search
  always_comb begin
    rd    = cdiv_q[CS].nq[VW-1:0];
    xl    = '0;
    yl    = '0;
    found = 1'b0;
    fx1   = '0;
    fx2   = '0;
    fy1   = '0;
    fy2   = '0;
    for (int i = 0; i < slpl_pkg::PT_LIMIT; i++) begin
      if (slpl_pkg::PT_W'(i) == cfg_i.n - 1'b1) begin
        xl = cfg_i.knee_x[i];
        yl = cfg_i.knee_y[i];
      end
    end
    for (int i = 0; i < slpl_pkg::PT_LIMIT - 1; i++) begin
      if (!found && (slpl_pkg::PT_W'(i + 1) < cfg_i.n) &&
          (rd >= cfg_i.knee_x[i]) && (rd <= cfg_i.knee_x[i+1])) begin
        found = 1'b1;
        fx1   = cfg_i.knee_x[i];
        fx2   = cfg_i.knee_x[i+1];
        fy1   = cfg_i.knee_y[i];
        fy2   = cfg_i.knee_y[i+1];
      end
    end
    seg_d.st     = cdiv_q[CS].st;
    seg_d.direct = 1'b1;
    seg_d.r      = rd;
    seg_d.x1     = '0;
    seg_d.x2     = '0;
    seg_d.y1     = '0;
    seg_d.y2     = '0;
    if (cdiv_q[CS].st == slpl_pkg::ST_OK) begin
      if (rd <= cfg_i.knee_x[0]) begin
        seg_d.y1 = cfg_i.knee_y[0];
      end else if ((cfg_i.n >= slpl_pkg::PT_W'(2)) && (rd >= xl)) begin
        seg_d.y1 = yl;
      end else if (found) begin
        seg_d.direct = 1'b0;
        seg_d.x1     = fx1;
        seg_d.x2     = fx2;
        seg_d.y1     = fy1;
        seg_d.y2     = fy2;
      end else begin
        seg_d.st = slpl_pkg::ST_NOSEG;
      end
    end
  end

  // slope numerator, wrapped to 16 bits
  always_comb begin
    dx   = seg_q.x2 - seg_q.x1;
    rise = seg_q.y2 > seg_q.y1;
    dy   = rise ? (seg_q.y2 - seg_q.y1) : (seg_q.y1 - seg_q.y2);
    diff = seg_q.r - seg_q.x1;
    prod = diff * dy;
    mul_d.st     = seg_q.st;
    mul_d.direct = seg_q.direct || (dx == '0);
    mul_d.rise   = rise;
    mul_d.y1     = seg_q.y1;
    mul_d.d      = dx;
    mul_d.p      = prod[VW-1:0];
  end

  // rounded quotient by segment width, one bit per stage
  always_comb begin
    idiv_d[0].st     = mul_q.st;
    idiv_d[0].direct = mul_q.direct;
    idiv_d[0].rise   = mul_q.rise;
    idiv_d[0].y1     = mul_q.y1;
    idiv_d[0].d      = mul_q.d;
    idiv_d[0].rem    = '0;
    idiv_d[0].nq     = mul_q.p + {1'b0, mul_q.d[VW-1:1]};
    itrial           = '0;
    for (int k = 0; k < IS; k++) begin
      itrial = {idiv_q[k].rem, idiv_q[k].nq[VW-1]};
      idiv_d[k+1].st     = idiv_q[k].st;
      idiv_d[k+1].direct = idiv_q[k].direct;
      idiv_d[k+1].rise   = idiv_q[k].rise;
      idiv_d[k+1].y1     = idiv_q[k].y1;
      idiv_d[k+1].d      = idiv_q[k].d;
      if (itrial >= {1'b0, idiv_q[k].d}) begin
        idiv_d[k+1].rem = VW'(itrial - {1'b0, idiv_q[k].d});
        idiv_d[k+1].nq  = {idiv_q[k].nq[VW-2:0], 1'b1};
      end else begin
        idiv_d[k+1].rem = itrial[VW-1:0];
        idiv_d[k+1].nq  = {idiv_q[k].nq[VW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    quo = idiv_q[IS].nq;
    case (idiv_q[IS].st)
      slpl_pkg::ST_OK: begin
        if (idiv_q[IS].direct) begin
          out_val_d = idiv_q[IS].y1;
        end else if (idiv_q[IS].rise) begin
          out_val_d = idiv_q[IS].y1 + quo;
        end else begin
          out_val_d = idiv_q[IS].y1 - quo;
        end
      end
      slpl_pkg::ST_FAULT: out_val_d = slpl_pkg::FAULT_VALUE;
      default:            out_val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cdiv_v_q <= '0;
      seg_v_q  <= 1'b0;
      mul_v_q  <= 1'b0;
      idiv_v_q <= '0;
      out_v_q  <= 1'b0;
    end else if (adv) begin
      cdiv_v_q <= {cdiv_v_q[CS-1:0], q_valid_i};
      seg_v_q  <= cdiv_v_q[CS];
      mul_v_q  <= seg_v_q;
      idiv_v_q <= {idiv_v_q[IS-1:0], mul_v_q};
      out_v_q  <= idiv_v_q[IS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= CS; k++) begin
        cdiv_q[k] <= cdiv_d[k];
      end
      seg_q <= seg_d;
      mul_q <= mul_d;
      for (int k = 0; k <= IS; k++) begin
        idiv_q[k] <= idiv_d[k];
      end
      out_val_q <= out_val_d;
      out_st_q  <= idiv_q[IS].st;
    end
  end

  assign out_valid_o      = out_v_q;
  assign physical_value_o = out_val_q;
  assign conv_status_o    = out_st_q;

endmodule

### rtl/sensor_adc_piecewise_linearize_top.sv
// Sensor ADC linearizer: each 8-bit sample word becomes a 16-bit physical value plus a 2-bit
// status (ok, fault, disabled, no segment). One word is accepted every clock while the
// queue is not full (in_stall_o low); both divisions (the sample-to-reading conversion
// and the interpolation step) are bit-per-stage pipelines, 24 and 16 stages long. A
// two-word queue sits between the input classifier and the arithmetic pipeline, so up to
// two more input words are accepted after the output stalls. Configuration registers
// reset to zero and take effect for words accepted after the write; write them only
// while no word is in flight.
`timescale 1ns / 1ps
`include "sensor_adc_piecewise_linearize_top_macros.svh"

module sensor_adc_piecewise_linearize_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [slpl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [slpl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [slpl_pkg::ADC_W-1:0]       adc_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [slpl_pkg::VAL_W-1:0]       physical_value_o,
  output logic [1:0]                       conv_status_o
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_valid;
  slpl_pkg::job_t front_job;
  slpl_pkg::job_t q_job;
  slpl_pkg::cfg_t cfg;

  slpl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .adc_sample_i (adc_sample_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .job_o        (front_job),
    .cfg_o        (cfg)
  );

  slpl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  slpl_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .q_valid_i        (q_valid),
    .q_job_i          (q_job),
    .q_pop_o          (q_pop),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .physical_value_o (physical_value_o),
    .conv_status_o    (conv_status_o)
  );

  assign in_stall_o = q_full;

  `SLPL_ASSERT_NOW(a_fault_value,
    out_valid_o && (conv_status_o == slpl_pkg::ST_FAULT),
    physical_value_o == slpl_pkg::FAULT_VALUE, "fault word without fault value")
  `SLPL_ASSERT_NOW(a_zero_value,
    out_valid_o && (conv_status_o == slpl_pkg::ST_DISABLED ||
                    conv_status_o == slpl_pkg::ST_NOSEG),
    physical_value_o == '0, "disabled or unmatched word not zero")
  `SLPL_ASSERT_NOW(a_hold_queue,
    out_valid_o && out_stall_i, !q_pop, "queue popped while output stalled")
  `SLPL_ASSERT_NEXT(a_push_lands,
    q_push && !q_pop, q_valid, "pushed word missing from queue")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import slpl_pkg::*;

  localparam int unsigned   PTS           = 6;
  localparam logic [7:0]    RES_FAULT_AD  = 8'd195;
  localparam logic [7:0]    VOLT_FAULT_AD = 8'd6;
  localparam logic [15:0]   FAULT_CODE    = 16'hfffe;
  localparam int unsigned   RES_OFS       = 127;
  localparam int unsigned   RES_DEN_BASE  = 242;
  localparam int unsigned   VOLT_DEN      = 480;
  localparam int unsigned   PIPE_TAIL     = 60;

  typedef struct packed {
    logic [15:0] value;
    status_e     st;
  } lin_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  adc_sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] physical_value_o;
  logic [1:0]  conv_status_o;

  logic [2:0]  cur_points = '0;
  logic        cur_kind   = 1'b0;
  logic [15:0] cur_ratio  = '0;
  logic [15:0] knee_x [PTS] = '{default: '0};
  logic [15:0] knee_y [PTS] = '{default: '0};
  logic [15:0] stage_x [PTS];
  logic [15:0] stage_y [PTS];

  logic [7:0]  sample_q [$];
  lin_result_t value_due_q [$];

  logic        in_took     = 1'b0;
  bit          in_idle_on  = 1'b1;
  bit          out_idle_on = 1'b1;
  int unsigned idle_odds   = 6;
  int unsigned in_gap      = 0;
  int unsigned out_gap     = 0;
  int unsigned pushed_cnt  = 0;
  int unsigned taken_cnt   = 0;
  int unsigned bad_cnt     = 0;
  int unsigned setting_cnt = 0;
  int unsigned st_cnt [4]  = '{default: 0};

  sensor_adc_piecewise_linearize_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .adc_sample_i     (adc_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .physical_value_o (physical_value_o),
    .conv_status_o    (conv_status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [15:0] blend(input logic [15:0] x1, input logic [15:0] y1,
                                        input logic [15:0] x2, input logic [15:0] y2,
                                        input logic [15:0] rd);
    logic [15:0] d;
    logic [15:0] dy;
    logic [15:0] q;
    logic [31:0] prod;
    d  = x2 - x1;
    dy = (y2 > y1) ? y2 - y1 : y1 - y2;
    if (d == 0) return y1;
    prod = 32'(16'(rd - x1)) * 32'(dy);
    q    = prod[15:0] + (d >> 1);
    q    = q / d;
    return (y2 > y1) ? 16'(y1 + q) : 16'(y1 - q);
  endfunction

  function automatic lin_result_t linearize(input logic [7:0] ad);
    lin_result_t res;
    int unsigned n;
    logic [31:0] num;
    logic [15:0] rd;
    res.value = '0;
    res.st    = ST_NOSEG;
    n = (cur_points > PTS) ? PTS : cur_points;
    if (n == 0) begin
      res.st = ST_DISABLED;
      return res;
    end
    if (!cur_kind) begin
      if (ad >= RES_FAULT_AD) begin
        res.value = FAULT_CODE;
        res.st    = ST_FAULT;
        return res;
      end
      num = 32'(cur_ratio) * 32'(ad) + 32'(RES_OFS) - 32'(ad >> 1);
      rd  = 16'(num / (32'(RES_DEN_BASE) - 32'(ad)));
    end else begin
      if (ad <= VOLT_FAULT_AD) begin
        res.value = FAULT_CODE;
        res.st    = ST_FAULT;
        return res;
      end
      num = 32'(cur_ratio) * 32'(ad);
      rd  = 16'(num / 32'(VOLT_DEN));
    end
    if (rd <= knee_x[0]) begin
      res.value = knee_y[0];
      res.st    = ST_OK;
    end else if (n >= 2 && rd >= knee_x[n-1]) begin
      res.value = knee_y[n-1];
      res.st    = ST_OK;
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        if (res.st == ST_NOSEG && rd >= knee_x[i] && rd <= knee_x[i+1]) begin
          res.value = blend(knee_x[i], knee_y[i], knee_x[i+1], knee_y[i+1], rd);
          res.st    = ST_OK;
        end
      end
    end
    return res;
  endfunction

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (sample_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (in_idle_on && $urandom_range(0, idle_odds) == 0) begin
        in_gap = $urandom_range(0, 12);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i   <= 1'b1;
        adc_sample_i <= sample_q.pop_front();
      end
    end
  end

  // output stall bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else if (out_idle_on && $urandom_range(0, idle_odds) == 0) begin
      out_gap = $urandom_range(0, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    lin_result_t want;
    if (rst_ni) begin
      in_took <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        value_due_q.push_back(linearize(adc_sample_i));
        taken_cnt++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (value_due_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("unexpected word: value %h status %0d", physical_value_o, conv_status_o);
        end else begin
          want = value_due_q.pop_front();
          st_cnt[want.st]++;
          if (want.value !== physical_value_o || want.st !== conv_status_o) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("mismatch: value %h status %0d, expected value %h status %0d",
                       physical_value_o, conv_status_o, want.value, want.st);
          end
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_POINT_COUNT: cur_points = val[2:0];
      REG_SENSOR_KIND: cur_kind   = val[0];
      REG_INPUT_RATIO: cur_ratio  = val[15:0];
      REG_KNEE_X_FIRST: begin
        knee_x[0] = val[15:0];
        knee_x[1] = val[31:16];
        knee_x[2] = val[47:32];
      end
      REG_KNEE_X_LAST: begin
        knee_x[3] = val[15:0];
        knee_x[4] = val[31:16];
        knee_x[5] = val[47:32];
      end
      REG_KNEE_Y_FIRST: begin
        knee_y[0] = val[15:0];
        knee_y[1] = val[31:16];
        knee_y[2] = val[47:32];
      end
      REG_KNEE_Y_LAST: begin
        knee_y[3] = val[15:0];
        knee_y[4] = val[31:16];
        knee_y[5] = val[47:32];
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_table(input logic [2:0] n, input logic kind, input logic [15:0] ratio);
    write_reg(REG_POINT_COUNT, 48'(n));
    write_reg(REG_SENSOR_KIND, 48'(kind));
    write_reg(REG_INPUT_RATIO, 48'(ratio));
    write_reg(REG_KNEE_X_FIRST, {stage_x[2], stage_x[1], stage_x[0]});
    write_reg(REG_KNEE_X_LAST,  {stage_x[5], stage_x[4], stage_x[3]});
    write_reg(REG_KNEE_Y_FIRST, {stage_y[2], stage_y[1], stage_y[0]});
    write_reg(REG_KNEE_Y_LAST,  {stage_y[5], stage_y[4], stage_y[3]});
    setting_cnt++;
  endtask

  task automatic feed(input logic [7:0] s);
    sample_q.push_back(s);
    pushed_cnt++;
  endtask

  task automatic drain();
    while (taken_cnt != pushed_cnt || value_due_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0]  picks [$];
    logic [2:0]  n;
    logic        kind;
    logic [15:0] ratio;
    int unsigned span;
    int unsigned step;
    int unsigned pick;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset: channel disabled
    feed(8'd0);
    feed(8'd255);
    drain();

    // resistive, count above limit, zero-width, rising and falling segments
    stage_x = '{16'd100, 16'd9000, 16'd9000, 16'd30000, 16'd50000, 16'd65000};
    stage_y = '{16'd500, 16'd4000, 16'd60000, 16'd100, 16'd65535, 16'd0};
    program_table(3'd7, 1'b0, 16'hffff);
    picks = '{8'd0, 8'd1, 8'd64, 8'd128, 8'd160, 8'd194, 8'd195, 8'd255};
    foreach (picks[i]) feed(picks[i]);
    drain();

    // voltage, single point
    stage_x = '{16'd10000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    stage_y = '{16'd1234, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    program_table(3'd1, 1'b1, 16'hffff);
    picks = '{8'd0, 8'd6, 8'd7, 8'd255};
    foreach (picks[i]) feed(picks[i]);
    drain();

    // voltage, full table with rising and falling segments
    stage_x = '{16'd100, 16'd500, 16'd1000, 16'd1500, 16'd2000, 16'd2500};
    stage_y = '{16'd65535, 16'd40000, 16'd40000, 16'd1000, 16'd0, 16'd65535};
    program_table(3'd6, 1'b1, 16'd4800);
    picks = '{8'd7, 8'd8, 8'd30, 8'd77, 8'd133, 8'd180, 8'd249, 8'd255};
    foreach (picks[i]) feed(picks[i]);
    drain();

    for (int p = 0; p < 20; p++) begin
      in_idle_on  = (p < 17) && ($urandom_range(0, 4) != 0);
      out_idle_on = (p < 17) && ($urandom_range(0, 4) != 0);
      idle_odds   = $urandom_range(3, 12);
      pick = $urandom_range(0, 11);
      n    = (pick == 0) ? 3'd0 : (pick == 1) ? 3'd7 : 3'($urandom_range(1, 6));
      kind = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0:       ratio = 16'd0;
        1:       ratio = 16'hffff;
        2:       ratio = 16'($urandom_range(1, 600));
        default: ratio = 16'($urandom);
      endcase
      span = $urandom_range(0, 1) ? 65535 : $urandom_range(16, 4096);
      step = span / PTS;
      for (int i = 0; i < PTS; i++) begin
        stage_x[i] = 16'(i * step + $urandom_range(0, step));
        if (i > 0 && $urandom_range(0, 7) == 0) stage_x[i] = stage_x[i-1];
        if ($urandom_range(0, 5) == 0) stage_x[i] = 16'($urandom);
        stage_y[i] = 16'($urandom);
      end
      if (p == 0) begin
        n     = 3'd6;
        ratio = 16'd0;
        stage_x = '{default: 16'd0};
        stage_y = '{default: 16'd0};
      end else if (p == 1) begin
        n     = 3'd7;
        ratio = 16'hffff;
        stage_x = '{default: 16'hffff};
        stage_y = '{default: 16'hffff};
      end
      program_table(n, kind, ratio);
      repeat ($urandom_range(55, 85)) feed(8'($urandom));
      drain();
    end

    repeat (PIPE_TAIL) @(negedge clk_i);
    $display("%0d samples linearized over %0d register settings", taken_cnt, setting_cnt);
    $display("results: %0d ok, %0d fault, %0d disabled, %0d no segment",
             st_cnt[ST_OK], st_cnt[ST_FAULT], st_cnt[ST_DISABLED], st_cnt[ST_NOSEG]);
    if (bad_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("timeout with %0d words outstanding", value_due_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
